// File: sv/ps2sa_pkg.sv
// Package for the PS/2 scan code set 2 to ASCII translator.
// Holds result kind codes, special scan codes and the key translation table.
// No dependencies.
package ps2sa_pkg;

   typedef enum logic [2:0] {
      KIND_CHAR     = 3'd0,
      KIND_RELEASE  = 3'd1,
      KIND_SELECT   = 3'd2,
      KIND_PREVIOUS = 3'd3,
      KIND_NEXT     = 3'd4
   } kind_type;

   localparam logic [7:0] CODE_BREAK  = 8'hF0;
   localparam logic [7:0] CODE_ACK    = 8'hFA;
   localparam logic [6:0] KEY_LSHIFT  = 7'h12;
   localparam logic [6:0] KEY_RSHIFT  = 7'h59;
   localparam logic [6:0] KEY_CTRL    = 7'h14;
   localparam logic [6:0] CHAR_PREV   = 7'd19;
   localparam logic [6:0] CHAR_NEXT   = 7'd4;
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_NINE   = 7'h39;

   // Translate a key code; shifted selects the upper table.
   function automatic logic [6:0] key_char(input logic [6:0] code, input logic shifted);
      logic [6:0] ch;
      ch = 7'h00;
      case (code)
         7'h0D: ch = shifted ? 7'h00 : 7'h09;
         7'h0E: ch = shifted ? 7'h7E : 7'h60;
         7'h15: ch = shifted ? 7'h51 : 7'h71;
         7'h16: ch = shifted ? 7'h21 : 7'h31;
         7'h1A: ch = shifted ? 7'h5A : 7'h7A;
         7'h1B: ch = shifted ? 7'h53 : 7'h73;
         7'h1C: ch = shifted ? 7'h41 : 7'h61;
         7'h1D: ch = shifted ? 7'h57 : 7'h77;
         7'h1E: ch = shifted ? 7'h40 : 7'h32;
         7'h21: ch = shifted ? 7'h43 : 7'h63;
         7'h22: ch = shifted ? 7'h58 : 7'h78;
         7'h23: ch = shifted ? 7'h44 : 7'h64;
         7'h24: ch = shifted ? 7'h45 : 7'h65;
         7'h25: ch = shifted ? 7'h24 : 7'h34;
         7'h26: ch = shifted ? 7'h23 : 7'h33;
         7'h29: ch = 7'h20;
         7'h2A: ch = shifted ? 7'h56 : 7'h76;
         7'h2B: ch = shifted ? 7'h46 : 7'h66;
         7'h2C: ch = shifted ? 7'h54 : 7'h74;
         7'h2D: ch = shifted ? 7'h52 : 7'h72;
         7'h2E: ch = shifted ? 7'h25 : 7'h35;
         7'h31: ch = shifted ? 7'h4E : 7'h6E;
         7'h32: ch = shifted ? 7'h42 : 7'h62;
         7'h33: ch = shifted ? 7'h48 : 7'h68;
         7'h34: ch = shifted ? 7'h47 : 7'h67;
         7'h35: ch = shifted ? 7'h59 : 7'h79;
         7'h36: ch = shifted ? 7'h5E : 7'h36;
         7'h3A: ch = shifted ? 7'h4D : 7'h6D;
         7'h3B: ch = shifted ? 7'h4A : 7'h6A;
         7'h3C: ch = shifted ? 7'h55 : 7'h75;
         7'h3D: ch = shifted ? 7'h26 : 7'h37;
         7'h3E: ch = shifted ? 7'h2A : 7'h38;
         7'h41: ch = shifted ? 7'h3C : 7'h2C;
         7'h42: ch = shifted ? 7'h4B : 7'h6B;
         7'h43: ch = shifted ? 7'h49 : 7'h69;
         7'h44: ch = shifted ? 7'h4F : 7'h6F;
         7'h45: ch = shifted ? 7'h29 : 7'h30;
         7'h46: ch = shifted ? 7'h28 : 7'h39;
         7'h49: ch = shifted ? 7'h3E : 7'h2E;
         7'h4A: ch = shifted ? 7'h3F : 7'h2F;
         7'h4B: ch = shifted ? 7'h4C : 7'h6C;
         7'h4C: ch = shifted ? 7'h3A : 7'h3B;
         7'h4D: ch = shifted ? 7'h50 : 7'h70;
         7'h4E: ch = shifted ? 7'h5F : 7'h2D;
         7'h52: ch = shifted ? 7'h22 : 7'h27;
         7'h54: ch = shifted ? 7'h7B : 7'h5B;
         7'h55: ch = shifted ? 7'h2B : 7'h3D;
         7'h5A: ch = 7'h0D;
         7'h5B: ch = shifted ? 7'h7D : 7'h5D;
         7'h5D: ch = shifted ? 7'h7C : 7'h5C;
         7'h66: ch = 7'h08;
         7'h6B: ch = 7'd19;
         7'h72: ch = 7'd24;
         7'h74: ch = 7'd4;
         7'h75: ch = 7'd5;
         7'h76: ch = 7'd27;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/ps2_scancode_to_ascii_core.sv
// Top level of the PS/2 scan code set 2 to ASCII translator.
// Depends on ps2sa_pkg for kind codes, scan code constants and the key table.
//
// Usage:
//   req channel: one scan code byte per beat on req_tdata[7:0].
//   rsp channel: zero or one result beat per request byte, in order.
//     rsp_tuser[2:0] kind (0 char, 1 release, 2 select, 3 previous, 4 next),
//     rsp_tdata[6:0] char_code, rsp_tdata[10:7] console_number, [15:11] zero.
//   Result: registered; appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless stalled; the whole translation is
//     one table lookup and a few compares from request port to result register.
//   Stall: the result register holds its beat while rsp_tready is low; a new
//     byte is still taken when the held beat leaves in the same cycle, else
//     req_tready drops until the result register frees up.
//   Reset: clears the held key map, the release-pending flag and the result
//     register valid. No clearing pass is needed.
//   Bytes that give no result (ignored codes, shift/ctrl, break prefix) are
//     absorbed and put no beat on the result channel.
module ps2_scancode_to_ascii_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic [15:0] rsp_tdata    // [6:0] char_code, [10:7] console_number
);
   import ps2sa_pkg::*;

   // Key map and release prefix flag.
   logic [127:0] held_keys_ff;
   logic [127:0] held_keys_in;
   logic         release_pending_ff;
   logic         release_pending_in;

   // Result register.
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   kind_type     kind_ff;
   kind_type     kind_in;
   logic [6:0]   char_code_ff;
   logic [6:0]   char_code_in;
   logic [3:0]   console_ff;
   logic [3:0]   console_in;

   logic         req_accept;
   logic         rsp_load;
   logic         emit;
   kind_type     emit_kind;
   logic [6:0]   emit_char;
   logic [3:0]   emit_console;
   logic [6:0]   key;
   logic [6:0]   ch;
   logic         shifted;

   // Result register is free when empty or being drained this cycle.
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = rsp_load;
   assign req_accept = req_tvalid && req_tready;

   assign key     = req_tdata[6:0];
   assign shifted = held_keys_ff[KEY_LSHIFT] || held_keys_ff[KEY_RSHIFT];
   assign ch      = key_char(key, shifted);

   // Decode one byte against the current key map.
   always_comb begin
      held_keys_in       = held_keys_ff;
      release_pending_in = release_pending_ff;
      emit               = 1'b0;
      emit_kind          = KIND_CHAR;
      emit_char          = 7'd0;
      emit_console       = 4'd0;
      if (release_pending_ff) begin
         // Byte after the break prefix names the released key, whatever it is.
         release_pending_in = 1'b0;
         if (!req_tdata[7] && key != 7'd0) begin
            held_keys_in[key] = 1'b0;
         end
         emit      = 1'b1;
         emit_kind = KIND_RELEASE;
      end else if (req_tdata == CODE_BREAK) begin
         release_pending_in = 1'b1;
      end else if (req_tdata == 8'd0 || req_tdata == CODE_ACK || req_tdata[7]) begin
         // drop
      end else begin
         held_keys_in[key] = 1'b1;
         if (key == KEY_LSHIFT || key == KEY_RSHIFT || key == KEY_CTRL) begin
            // modifier only
         end else if (!held_keys_ff[KEY_CTRL]) begin
            emit      = (ch != 7'd0);
            emit_kind = KIND_CHAR;
            emit_char = ch;
         end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            // Console digits: low nibble of '0'..'9' is the value.
            emit         = 1'b1;
            emit_kind    = KIND_SELECT;
            emit_console = ch[3:0];
         end else if (ch == CHAR_PREV) begin
            emit      = 1'b1;
            emit_kind = KIND_PREVIOUS;
         end else if (ch == CHAR_NEXT) begin
            emit      = 1'b1;
            emit_kind = KIND_NEXT;
         end
      end
   end

   // Next state of the result register: load when free, else hold.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      char_code_in = char_code_ff;
      console_in   = console_ff;
      if (rsp_load) begin
         rsp_valid_in = req_accept && emit;
         kind_in      = emit_kind;
         char_code_in = emit_char;
         console_in   = emit_console;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_keys_ff       <= '0;
         release_pending_ff <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_accept) begin
            held_keys_ff       <= held_keys_in;
            release_pending_ff <= release_pending_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      char_code_ff <= char_code_in;
      console_ff   <= console_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {5'b00000, console_ff, char_code_ff};

`ifndef SYNTH
   // A byte taken while a release is pending always yields a release beat.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && release_pending_ff |=> rsp_tvalid && kind_ff == KIND_RELEASE)
      else $error("release byte did not produce a release beat");

   // The pending flag never survives the byte that consumes it.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && release_pending_ff |=> !release_pending_ff)
      else $error("release pending flag not cleared");

   // A break prefix arms the flag and gives no result.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !release_pending_ff && req_tdata == CODE_BREAK
      |=> release_pending_ff && !rsp_tvalid)
      else $error("break prefix handled wrongly");

   // Character beats carry a nonzero character and no console number.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff == KIND_CHAR |-> char_code_ff != 7'd0 && console_ff == 4'd0)
      else $error("malformed character beat");

   // Non-character beats (release and console) carry no character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff != KIND_CHAR |-> char_code_ff == 7'd0)
      else $error("non-character beat carries a character");
`endif

endmodule
